>>> hdl/ellipsoid_point_pushout_core_defines.svh
// assertion helpers shared by the ellipsoid push-out core
`ifndef ELLIPSOID_POINT_PUSHOUT_CORE_DEFINES_SVH
`define ELLIPSOID_POINT_PUSHOUT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/epp_pkg.sv
package epp_pkg;

    // coordinate format and rotation entry format
    localparam int CW  = 21;
    localparam int MFB = 14;
    localparam int RW  = 16;

    // derived datapath widths
    localparam int DW   = CW + 1;
    localparam int PW   = RW + DW;
    localparam int AW   = PW + 2;
    localparam int LW   = AW - MFB;
    localparam int NPW  = 2 * CW + 1;
    localparam int NSH  = 4;
    localparam int NW   = 17;
    localparam int QW   = 2 * (NW - 1);
    localparam int LENW = QW / 2;
    localparam int SQSTEPS = QW / 2;
    localparam int MW   = NW + CW;
    localparam int QTW  = CW;
    localparam int SW   = CW + 1;
    localparam int BPW  = RW + SW;

    // register file
    localparam int REG_COORD_W = 3 * CW;
    localparam int REG_ROT_W   = 3 * RW;
    localparam int CFG_DW      = REG_COORD_W;
    localparam int CFG_AW      = 3;
    localparam logic [CFG_AW-1:0] REG_CENTER    = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_HALF      = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_INV_HALF  = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_ROT_X     = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] REG_ROT_Y     = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] REG_ROT_Z     = CFG_AW'(5);
    localparam logic [RW-1:0]     ROT_ONE       = RW'(1 << MFB);

    // stream packing
    localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = 2;

    typedef struct packed {
        logic [2:0][CW-1:0]         center;
        logic [2:0][CW-1:0]         half;
        logic [2:0][CW-1:0]         inv;
        logic [2:0][2:0][RW-1:0]    rot;
    } cfg_t;

    // classified point handed from front to back
    typedef struct packed {
        logic                   hit;
        logic [2:0][CW-1:0]     p;
        logic [2:0][NW-1:0]     n;
        logic [QW-1:0]          q;
    } rec_t;

    typedef struct packed {
        logic           full;
        logic [FAW:0]   level;
    } fifo_stat_t;

    // rotation sum back to coordinate scale, rounded half up
    function automatic logic signed [LW-1:0] rnd_rot(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        t = acc + AW'(1 << (MFB - 1));
        return LW'(t >>> MFB);
    endfunction

endpackage

>>> hdl/ellipsoid_point_pushout_core.sv
// Oriented ellipsoid push-out: each point on the s_ stream is moved into the
// ellipsoid frame, tested, and if inside pushed to the surface and moved back;
// m_tuser carries the hit flag and m_tdata the resulting point (the input point
// on no hit). One point is taken every clock while the front pipe is not held
// by a full queue; a point passes the front pipe, the 4-entry queue and the
// back pipe, a depth set by the 16-step square root and the 21-step divider.
// The queue lets the front keep accepting while the output is stalled. The
// configuration registers are to be written only while no point is in flight.
`include "ellipsoid_point_pushout_core_defines.svh"

module ellipsoid_point_pushout_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [epp_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [epp_pkg::CFG_DW-1:0]      cfg_wdata,
    // input points
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [epp_pkg::TDATA_W-1:0]     s_tdata,   // point_x, point_y, point_z
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [epp_pkg::TDATA_W-1:0]     m_tdata,   // pushed_x, pushed_y, pushed_z
    output logic                            m_tuser    // hit
);

    logic [epp_pkg::REG_COORD_W-1:0]    center_reg, half_reg, inv_reg;
    logic [epp_pkg::REG_ROT_W-1:0]      rot_x_reg, rot_y_reg, rot_z_reg;
    epp_pkg::cfg_t                      cfg;

    logic [2:0][epp_pkg::CW-1:0]        in_p;
    logic                               f_valid, f_ready;
    epp_pkg::rec_t                      f_rec;
    logic                               q_valid, q_ready;
    epp_pkg::rec_t                      q_rec;
    epp_pkg::fifo_stat_t                fifo_stat;
    logic [2:0][epp_pkg::CW-1:0]        pushed;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            half_reg   <= '0;
            inv_reg    <= '0;
            rot_x_reg  <= {{(2*epp_pkg::RW){1'b0}}, epp_pkg::ROT_ONE};
            rot_y_reg  <= {{epp_pkg::RW{1'b0}}, epp_pkg::ROT_ONE, {epp_pkg::RW{1'b0}}};
            rot_z_reg  <= {epp_pkg::ROT_ONE, {(2*epp_pkg::RW){1'b0}}};
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                epp_pkg::REG_CENTER:   center_reg <= cfg_wdata[epp_pkg::REG_COORD_W-1:0];
                epp_pkg::REG_HALF:     half_reg   <= cfg_wdata[epp_pkg::REG_COORD_W-1:0];
                epp_pkg::REG_INV_HALF: inv_reg    <= cfg_wdata[epp_pkg::REG_COORD_W-1:0];
                epp_pkg::REG_ROT_X:    rot_x_reg  <= cfg_wdata[epp_pkg::REG_ROT_W-1:0];
                epp_pkg::REG_ROT_Y:    rot_y_reg  <= cfg_wdata[epp_pkg::REG_ROT_W-1:0];
                epp_pkg::REG_ROT_Z:    rot_z_reg  <= cfg_wdata[epp_pkg::REG_ROT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.center = center_reg;
    assign cfg.half   = half_reg;
    assign cfg.inv    = inv_reg;
    assign cfg.rot[0] = rot_x_reg;
    assign cfg.rot[1] = rot_y_reg;
    assign cfg.rot[2] = rot_z_reg;

    assign in_p = s_tdata[3*epp_pkg::CW-1:0];

    // classify: local frame, box test, normalized length squared
    epp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_p      (in_p),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_rec   (f_rec)
    );

    epp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rec),
        .stat     (fifo_stat)
    );

    // push-out: square root, divide, rotate back
    epp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_rec     (q_rec),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (m_tuser),
        .out_pushed (pushed)
    );

    assign m_tdata = epp_pkg::TDATA_W'(pushed);

    // queue never overfills
    `EPP_ASSERT_IMPL(a_fifo_level_max, 1'b1,
        fifo_stat.level <= (epp_pkg::FAW+1)'(epp_pkg::FIFO_DEPTH), "queue level over depth")
    // level moves by at most one entry per cycle
    `EPP_ASSERT_IMPL(a_fifo_level_step, $past(aresetn),
        (fifo_stat.level == $past(fifo_stat.level)) ||
        (fifo_stat.level == $past(fifo_stat.level) + 1'b1) ||
        (fifo_stat.level + 1'b1 == $past(fifo_stat.level)), "queue level jumped")
    // with room in the queue the input is never held off
    `EPP_ASSERT_IMPL(a_ready_when_room, !fifo_stat.full, s_tready,
        "input stalled with queue space free")

endmodule

>>> hdl/epp_front.sv
module epp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  epp_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0][epp_pkg::CW-1:0]         in_p,
    output logic                                out_valid,
    input  logic                                out_ready,
    output epp_pkg::rec_t                       out_rec
);

    localparam int FST = 7;

    logic [FST-1:0] vld_reg;
    logic           adv;

    logic [2:0][epp_pkg::CW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [epp_pkg::DW-1:0]  d_next [3];
    logic signed [epp_pkg::DW-1:0]  d1_reg [3];
    logic signed [epp_pkg::PW-1:0]  prod_next [3][3];
    logic signed [epp_pkg::PW-1:0]  prod2_reg [3][3];
    logic signed [epp_pkg::LW-1:0]  l_next [3];
    logic signed [epp_pkg::LW-1:0]  l3_reg [3];
    logic                           pass_next, pass3_reg, pass4_reg;
    logic signed [epp_pkg::NPW-1:0] np_next [3];
    logic signed [epp_pkg::NPW-1:0] np4_reg [3];
    logic [2:0][epp_pkg::NW-1:0]    n_next, n5_reg, n6_reg;
    logic                           hit5_next, hit5_reg, hit6_reg;
    logic [epp_pkg::QW-1:0]         sq_next [3];
    logic [epp_pkg::QW-1:0]         sq6_reg [3];
    epp_pkg::rec_t                  rec_next, rec7_reg;

    // whole pipe moves when its last stage is empty or drained
    assign adv       = !vld_reg[FST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[FST-1];
    assign out_rec   = rec7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FST-2:0], in_valid};
        end
    end

    // offset, rotation products, local point and box test
    always_comb begin
        logic signed [epp_pkg::AW-1:0] acc;
        logic signed [epp_pkg::LW-1:0] e_ext;
        logic [2:0]                    ok;
        for (int k = 0; k < 3; k++) begin
            d_next[k] = epp_pkg::DW'($signed(in_p[k]))
                      - epp_pkg::DW'($signed(cfg.center[k]));
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[k][j] = epp_pkg::PW'($signed(cfg.rot[k][j]))
                                * epp_pkg::PW'(d1_reg[j]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            acc = epp_pkg::AW'(prod2_reg[k][0]) + epp_pkg::AW'(prod2_reg[k][1])
                + epp_pkg::AW'(prod2_reg[k][2]);
            l_next[k] = epp_pkg::rnd_rot(acc);
            e_ext = epp_pkg::LW'($signed(cfg.half[k]));
            ok[k] = !(l_next[k] > e_ext) && !(l_next[k] < -e_ext);
        end
        pass_next = &ok;
    end

    // normalized coordinates and their range check
    always_comb begin
        logic signed [epp_pkg::NPW-1:0] nfull;
        logic [2:0]                     inr;
        for (int k = 0; k < 3; k++) begin
            np_next[k] = epp_pkg::NPW'($signed(l3_reg[k][epp_pkg::CW-1:0]))
                       * epp_pkg::NPW'($signed({1'b0, cfg.inv[k]}));
        end
        for (int k = 0; k < 3; k++) begin
            nfull = (np4_reg[k] + epp_pkg::NPW'(1 << (epp_pkg::NSH - 1))) >>> epp_pkg::NSH;
            inr[k] = (nfull < epp_pkg::NPW'(1 << (epp_pkg::NW - 1)))
                  && (nfull > -epp_pkg::NPW'(1 << (epp_pkg::NW - 1)));
            n_next[k] = nfull[epp_pkg::NW-1:0];
        end
        hit5_next = pass4_reg && (&inr);
    end

    // squares and length squared
    always_comb begin
        logic signed [2*epp_pkg::NW-1:0] sqf;
        logic [epp_pkg::QW+1:0]          sum;
        for (int k = 0; k < 3; k++) begin
            sqf = (2*epp_pkg::NW)'($signed(n5_reg[k])) * (2*epp_pkg::NW)'($signed(n5_reg[k]));
            sq_next[k] = sqf[epp_pkg::QW-1:0];
        end
        sum = (epp_pkg::QW+2)'(sq6_reg[0]) + (epp_pkg::QW+2)'(sq6_reg[1])
            + (epp_pkg::QW+2)'(sq6_reg[2]);
        rec_next.hit = hit6_reg && (sum[epp_pkg::QW+1:epp_pkg::QW] == 2'b00);
        rec_next.p   = p6_reg;
        rec_next.n   = n6_reg;
        rec_next.q   = sum[epp_pkg::QW-1:0];
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= in_p;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
            p6_reg <= p5_reg;
            for (int k = 0; k < 3; k++) begin
                d1_reg[k]  <= d_next[k];
                l3_reg[k]  <= l_next[k];
                np4_reg[k] <= np_next[k];
                sq6_reg[k] <= sq_next[k];
                for (int j = 0; j < 3; j++) begin
                    prod2_reg[k][j] <= prod_next[k][j];
                end
            end
            pass3_reg <= pass_next;
            pass4_reg <= pass3_reg;
            n5_reg    <= n_next;
            n6_reg    <= n5_reg;
            hit5_reg  <= hit5_next;
            hit6_reg  <= hit5_reg;
            rec7_reg  <= rec_next;
        end
    end

endmodule

>>> hdl/epp_fifo.sv
module epp_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  epp_pkg::rec_t           wr_data,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output epp_pkg::rec_t           rd_data,
    output epp_pkg::fifo_stat_t     stat
);

    epp_pkg::rec_t                mem_reg [epp_pkg::FIFO_DEPTH];
    logic [epp_pkg::FAW-1:0]      wp_reg, rp_reg;
    logic [epp_pkg::FAW:0]        level_reg;
    logic                         push, pop;

    assign wr_ready   = (level_reg != (epp_pkg::FAW+1)'(epp_pkg::FIFO_DEPTH));
    assign rd_valid   = (level_reg != '0);
    assign rd_data    = mem_reg[rp_reg];
    assign push       = wr_valid && wr_ready;
    assign pop        = rd_valid && rd_ready;
    assign stat.full  = !wr_ready;
    assign stat.level = level_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/epp_back.sv
module epp_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  epp_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  epp_pkg::rec_t                       in_rec,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_hit,
    output logic [2:0][epp_pkg::CW-1:0]         out_pushed
);

    // step numbering along the pipe
    localparam int T_MUL = epp_pkg::SQSTEPS;
    localparam int T_ABS = T_MUL + 1;
    localparam int T_DIV = T_ABS + 1;
    localparam int T_SF  = T_DIV + epp_pkg::QTW;
    localparam int T_BM  = T_SF + 1;
    localparam int NB    = T_BM + 2;

    typedef struct packed {
        logic                           hit;
        logic                           qzero;
        logic [2:0][epp_pkg::CW-1:0]    p;
        logic [2:0][epp_pkg::NW-1:0]    n;
    } bk_t;

    logic [NB-1:0]  vld_reg;
    logic           adv;
    bk_t            pl_head;
    bk_t            pl_reg [NB-1];

    logic [epp_pkg::QW:0]   sv_reg [epp_pkg::SQSTEPS];
    logic [epp_pkg::QW:0]   sr_reg [epp_pkg::SQSTEPS];

    logic signed [epp_pkg::MW-1:0]  num_reg [3];
    logic [epp_pkg::LENW-1:0]       len_m_reg, len_a_reg;
    logic [epp_pkg::MW-1:0]         dv_reg [3];
    logic [2:0]                     neg_reg;

    logic [epp_pkg::LENW-1:0]       dr_reg [epp_pkg::QTW][3];
    logic [epp_pkg::QTW-1:0]        dq_reg [epp_pkg::QTW][3];
    logic [2:0]                     dn_reg [epp_pkg::QTW];
    logic [epp_pkg::LENW-1:0]       dl_reg [epp_pkg::QTW];

    logic signed [epp_pkg::SW-1:0]  s_reg [3];
    logic signed [epp_pkg::BPW-1:0] bp_reg [3][3];

    logic                           hit_reg;
    logic [2:0][epp_pkg::CW-1:0]    pushed_reg, pushed_next;

    assign adv        = !vld_reg[NB-1] || out_ready;
    assign in_ready   = adv;
    assign out_valid  = vld_reg[NB-1];
    assign out_hit    = hit_reg;
    assign out_pushed = pushed_reg;

    assign pl_head.hit   = in_rec.hit;
    assign pl_head.qzero = (in_rec.q == '0);
    assign pl_head.p     = in_rec.p;
    assign pl_head.n     = in_rec.n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NB-2:0], in_valid};
        end
    end

    // per-point fields ride along with the arithmetic
    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_reg[0] <= pl_head;
            for (int t = 1; t < NB - 1; t++) begin
                pl_reg[t] <= pl_reg[t-1];
            end
        end
    end

    // square root, one result bit per step
    for (genvar t = 0; t < epp_pkg::SQSTEPS; t++) begin : g_sqrt
        localparam logic [epp_pkg::QW:0] BIT =
            (epp_pkg::QW+1)'(1) << (epp_pkg::QW - 2 - 2 * t);
        logic [epp_pkg::QW:0] v_in, r_in, trial, v_next, r_next;
        if (t == 0) begin : g_first
            assign v_in = {1'b0, in_rec.q};
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = sv_reg[t-1];
            assign r_in = sr_reg[t-1];
        end
        always_comb begin
            trial = r_in + BIT;
            if (v_in >= trial) begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + BIT;
            end else begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sv_reg[t] <= v_next;
                sr_reg[t] <= r_next;
            end
        end
    end

    // numerator n * e and rounded dividend magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            len_m_reg <= sr_reg[epp_pkg::SQSTEPS-1][epp_pkg::LENW-1:0];
            len_a_reg <= len_m_reg;
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= epp_pkg::MW'($signed(pl_reg[T_MUL-1].n[k]))
                            * epp_pkg::MW'($signed(cfg.half[k]));
                neg_reg[k] <= num_reg[k][epp_pkg::MW-1];
                dv_reg[k]  <= (num_reg[k][epp_pkg::MW-1] ? epp_pkg::MW'(-num_reg[k])
                                                          : epp_pkg::MW'(num_reg[k]))
                            + epp_pkg::MW'(len_m_reg >> 1);
            end
        end
    end

    // restoring divider, one quotient bit per step
    for (genvar i = 0; i < epp_pkg::QTW; i++) begin : g_div
        logic [epp_pkg::LENW-1:0] r_in [3];
        logic [epp_pkg::QTW-1:0]  qd_in [3];
        logic [2:0]               neg_in;
        logic [epp_pkg::LENW-1:0] len_in;
        if (i == 0) begin : g_first
            always_comb begin
                for (int k = 0; k < 3; k++) begin
                    r_in[k]  = dv_reg[k][epp_pkg::QTW +: epp_pkg::LENW];
                    qd_in[k] = dv_reg[k][epp_pkg::QTW-1:0];
                end
                neg_in = neg_reg;
                len_in = len_a_reg;
            end
        end else begin : g_rest
            always_comb begin
                for (int k = 0; k < 3; k++) begin
                    r_in[k]  = dr_reg[i-1][k];
                    qd_in[k] = dq_reg[i-1][k];
                end
                neg_in = dn_reg[i-1];
                len_in = dl_reg[i-1];
            end
        end
        always_ff @(posedge aclk) begin
            logic [epp_pkg::LENW:0] trial;
            logic                   ge;
            if (adv) begin
                for (int k = 0; k < 3; k++) begin
                    trial = {r_in[k], qd_in[k][epp_pkg::QTW-1]};
                    ge    = (trial >= {1'b0, len_in});
                    dr_reg[i][k] <= ge ? epp_pkg::LENW'(trial - {1'b0, len_in})
                                       : trial[epp_pkg::LENW-1:0];
                    dq_reg[i][k] <= {qd_in[k][epp_pkg::QTW-2:0], ge};
                end
                dn_reg[i] <= neg_in;
                dl_reg[i] <= len_in;
            end
        end
    end

    // signed surface point and back-rotation products
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                if (pl_reg[T_SF-1].qzero) begin
                    s_reg[k] <= epp_pkg::SW'($signed(cfg.half[k]));
                end else if (dn_reg[epp_pkg::QTW-1][k]) begin
                    s_reg[k] <= -$signed({1'b0, dq_reg[epp_pkg::QTW-1][k]});
                end else begin
                    s_reg[k] <= $signed({1'b0, dq_reg[epp_pkg::QTW-1][k]});
                end
            end
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    bp_reg[j][k] <= epp_pkg::BPW'($signed(cfg.rot[k][j]))
                                  * epp_pkg::BPW'(s_reg[k]);
                end
            end
        end
    end

    // world frame, center added, saturated; echo input on no hit
    always_comb begin
        logic signed [epp_pkg::AW-1:0] acc;
        logic signed [epp_pkg::LW-1:0] w;
        logic signed [epp_pkg::LW:0]   t;
        for (int j = 0; j < 3; j++) begin
            acc = epp_pkg::AW'(bp_reg[j][0]) + epp_pkg::AW'(bp_reg[j][1])
                + epp_pkg::AW'(bp_reg[j][2]);
            w = epp_pkg::rnd_rot(acc);
            t = (epp_pkg::LW+1)'(w) + (epp_pkg::LW+1)'($signed(cfg.center[j]));
            if (!pl_reg[NB-2].hit) begin
                pushed_next[j] = pl_reg[NB-2].p[j];
            end else if (t > (epp_pkg::LW+1)'((1 << (epp_pkg::CW - 1)) - 1)) begin
                pushed_next[j] = {1'b0, {(epp_pkg::CW-1){1'b1}}};
            end else if (t < -(epp_pkg::LW+1)'(1 << (epp_pkg::CW - 1))) begin
                pushed_next[j] = {1'b1, {(epp_pkg::CW-1){1'b0}}};
            end else begin
                pushed_next[j] = t[epp_pkg::CW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg    <= pl_reg[NB-2].hit;
            pushed_reg <= pushed_next;
        end
    end

endmodule
